// ===== hw/rtl/empm_pkg.sv =====
// shared types, constants and codes for the expanded memory page mapper
package empm_pkg;

    localparam int TOTAL_PAGES  = 1024;
    localparam int HANDLE_COUNT = 255;
    localparam int HANDLES      = 256;
    localparam int WINDOWS      = 4;
    localparam int PAGE_W       = 11;

    localparam logic [10:0] SYS_PAGES   = 11'd4;
    localparam logic [15:0] FRAME_RESET = 16'hE000;
    localparam logic [15:0] VERSION     = 16'h0032;
    localparam logic [15:0] MAP_SIZE    = 16'd8;

    localparam logic [3:0] FN_STATUS  = 4'd0;
    localparam logic [3:0] FN_FRAME   = 4'd1;
    localparam logic [3:0] FN_COUNTS  = 4'd2;
    localparam logic [3:0] FN_ALLOC   = 4'd3;
    localparam logic [3:0] FN_MAP     = 4'd4;
    localparam logic [3:0] FN_FREE    = 4'd5;
    localparam logic [3:0] FN_VERSION = 4'd6;
    localparam logic [3:0] FN_SAVE    = 4'd7;
    localparam logic [3:0] FN_RESTORE = 4'd8;
    localparam logic [3:0] FN_OPEN    = 4'd9;
    localparam logic [3:0] FN_PAGES   = 4'd10;
    localparam logic [3:0] FN_GETMAP  = 4'd11;
    localparam logic [3:0] FN_MAPSIZE = 4'd12;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_HANDLE  = 4'd1;
    localparam logic [3:0] ST_UNKNOWN     = 4'd2;
    localparam logic [3:0] ST_NO_HANDLE   = 4'd3;
    localparam logic [3:0] ST_OVER_TOTAL  = 4'd4;
    localparam logic [3:0] ST_OVER_FREE   = 4'd5;
    localparam logic [3:0] ST_ZERO_PAGES  = 4'd6;
    localparam logic [3:0] ST_BAD_LOGICAL = 4'd7;
    localparam logic [3:0] ST_BAD_WINDOW  = 4'd8;

    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  handle;
        logic [15:0] page_count;
        logic [15:0] lpage;
        logic [7:0]  window;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic       set_en;
        logic       clr_en;
        logic [7:0] idx;
    } hctl_t;

    typedef struct packed {
        logic       any;
        logic [7:0] handle;
    } hfind_t;

endpackage

// ===== hw/rtl/empm_ram.sv =====
// generic synchronous ram, one write port and one registered read port
module empm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/empm_alloc.sv =====
// handle in-use flags and a registered lowest-free-handle search
module empm_alloc
    import empm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hctl_t      ctl,
    input  logic [7:0] rd_idx,
    output logic       rd_bit,
    output hfind_t     find
);

    logic [HANDLES-1:0] in_use_reg;
    logic [15:0]        grp_any_reg;
    logic [15:0][3:0]   grp_pos_reg;
    logic [15:0]        grp_any_next;
    logic [15:0][3:0]   grp_pos_next;
    logic [HANDLES-1:0] avail;

    assign rd_bit = in_use_reg[rd_idx];

    // first level: lowest free handle inside each group of sixteen
    always_comb
    begin
        for (int i = 0; i < HANDLES; i++)
        begin
            avail[i] = !in_use_reg[i] && (i >= 1) && (i <= HANDLE_COUNT);
        end
        for (int g = 0; g < 16; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_pos_next[g] = 4'd0;
            for (int b = 15; b >= 0; b--)
            begin
                if (avail[g*16 + b])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_pos_next[g] = 4'(b);
                end
            end
        end
    end

    // second level over the registered group results
    always_comb
    begin
        find.any    = 1'b0;
        find.handle = 8'd0;
        for (int g = 15; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                find.any    = 1'b1;
                find.handle = {4'(g), grp_pos_reg[g]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= HANDLES'(1);
            grp_any_reg <= '0;
            grp_pos_reg <= '0;
        end
        else
        begin
            if (ctl.set_en)
            begin
                in_use_reg[ctl.idx] <= 1'b1;
            end
            else if (ctl.clr_en)
            begin
                in_use_reg[ctl.idx] <= 1'b0;
            end
            grp_any_reg <= grp_any_next;
            grp_pos_reg <= grp_pos_next;
        end
    end

endmodule

// ===== hw/rtl/expanded_memory_page_mapper.sv =====
// top level: request sequencer, pools, window map and saved-map storage
//
// Takes one request at a time. A request passes through latch, RAM read and
// execute states to its result item, which waits until taken; restore adds a
// page-count RAM read and a check for each window, and get map hands out four
// items. Per-handle page counts and saved window maps live in single-port-read
// RAMs; in-use and saved-map valid flags are flip-flops, so no clearing pass
// follows reset. The free handle search is a registered two-level tree that
// is refreshed every cycle.
module expanded_memory_page_mapper
    import empm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_RSA  = 3'd3;
    localparam logic [2:0] S_RSB  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    req_t                req_reg, req_next;
    rsp_t                rsp_reg, rsp_next;
    logic [1:0]          idx_reg, idx_next;
    logic [15:0]         frame_reg;
    logic [10:0]         free_pages_reg, free_pages_next;
    logic [7:0]          fhc_reg, fhc_next;
    logic [3:0][7:0]     win_h_reg, win_h_next;
    logic [3:0][15:0]    win_p_reg, win_p_next;
    logic [3:0][7:0]     rst_h_reg, rst_h_next;
    logic [3:0][15:0]    rst_p_reg, rst_p_next;
    logic [HANDLES-1:0]  saved_vld_reg, saved_vld_next;

    logic                pg_we;
    logic [7:0]          pg_waddr;
    logic [10:0]         pg_wdata;
    logic [7:0]          pg_raddr;
    logic [10:0]         pg_q;
    logic                sv_we;
    logic [95:0]         sv_wdata;
    logic [95:0]         sv_q;

    hctl_t               hctl;
    hfind_t              hfind;
    logic [7:0]          use_idx;
    logic                use_bit;
    logic [10:0]         pg_val;

    empm_ram #(.WIDTH(PAGE_W), .DEPTH(HANDLES)) u_pages (
        .clk     (clk),
        .wr_en   (pg_we),
        .wr_addr (pg_waddr),
        .wr_data (pg_wdata),
        .rd_addr (pg_raddr),
        .rd_data (pg_q)
    );

    empm_ram #(.WIDTH(96), .DEPTH(HANDLES)) u_saved (
        .clk     (clk),
        .wr_en   (sv_we),
        .wr_addr (req_reg.handle),
        .wr_data (sv_wdata),
        .rd_addr (req_reg.handle),
        .rd_data (sv_q)
    );

    empm_alloc u_alloc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (hctl),
        .rd_idx (use_idx),
        .rd_bit (use_bit),
        .find   (hfind)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;

    assign pg_raddr = (state_reg == S_RSA) ? rst_h_reg[idx_reg] : req_reg.handle;
    assign use_idx  = (state_reg == S_RSB) ? rst_h_reg[idx_reg] : req_reg.handle;
    // pages of a handle that is not in use read as zero, system handle fixed
    assign pg_val   = (use_idx == 8'd0) ? SYS_PAGES : (use_bit ? pg_q : 11'd0);
    assign sv_wdata = {win_p_reg, win_h_reg};

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        idx_next        = idx_reg;
        free_pages_next = free_pages_reg;
        fhc_next        = fhc_reg;
        win_h_next      = win_h_reg;
        win_p_next      = win_p_reg;
        rst_h_next      = rst_h_reg;
        rst_p_next      = rst_p_reg;
        saved_vld_next  = saved_vld_reg;
        pg_we           = 1'b0;
        pg_waddr        = hfind.handle;
        pg_wdata        = req_reg.page_count[10:0];
        sv_we           = 1'b0;
        hctl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EX;
            end
            S_EX:
            begin
                rsp_next   = '{status: ST_OK, first_word: 16'd0, second_word: 16'd0,
                               last: 1'b1};
                state_next = S_OUT;
                case (req_reg.func)
                    FN_STATUS:
                    begin
                    end
                    FN_FRAME:
                    begin
                        rsp_next.first_word = frame_reg;
                    end
                    FN_COUNTS:
                    begin
                        rsp_next.first_word  = {5'd0, free_pages_reg};
                        rsp_next.second_word = 16'(TOTAL_PAGES);
                    end
                    FN_ALLOC:
                    begin
                        if (req_reg.page_count > 16'(TOTAL_PAGES))
                        begin
                            rsp_next.status = ST_OVER_TOTAL;
                        end
                        else if (req_reg.page_count > {5'd0, free_pages_reg})
                        begin
                            rsp_next.status = ST_OVER_FREE;
                        end
                        else if (req_reg.page_count == 16'd0)
                        begin
                            rsp_next.status = ST_ZERO_PAGES;
                        end
                        else if (fhc_reg == 8'd0 || !hfind.any)
                        begin
                            rsp_next.status = ST_NO_HANDLE;
                        end
                        else
                        begin
                            pg_we               = 1'b1;
                            hctl.set_en         = 1'b1;
                            hctl.idx            = hfind.handle;
                            free_pages_next     = free_pages_reg - req_reg.page_count[10:0];
                            fhc_next            = fhc_reg - 8'd1;
                            rsp_next.first_word = {8'd0, hfind.handle};
                        end
                    end
                    FN_MAP:
                    begin
                        if (req_reg.window > 8'd3)
                        begin
                            rsp_next.status = ST_BAD_WINDOW;
                        end
                        else if (req_reg.handle != 8'd0
                                 && {5'd0, pg_val} <= req_reg.lpage)
                        begin
                            rsp_next.status = ST_BAD_LOGICAL;
                        end
                        else
                        begin
                            win_h_next[req_reg.window[1:0]] = req_reg.handle;
                            win_p_next[req_reg.window[1:0]] = req_reg.lpage;
                        end
                    end
                    FN_FREE:
                    begin
                        if (req_reg.handle == 8'd0 || !use_bit)
                        begin
                            rsp_next.status = ST_BAD_HANDLE;
                        end
                        else
                        begin
                            hctl.clr_en     = 1'b1;
                            hctl.idx        = req_reg.handle;
                            free_pages_next = free_pages_reg + pg_val;
                            fhc_next        = fhc_reg + 8'd1;
                        end
                    end
                    FN_VERSION:
                    begin
                        rsp_next.first_word = VERSION;
                    end
                    FN_SAVE:
                    begin
                        sv_we                          = 1'b1;
                        saved_vld_next[req_reg.handle] = 1'b1;
                    end
                    FN_RESTORE:
                    begin
                        if (saved_vld_reg[req_reg.handle])
                        begin
                            rst_h_next = sv_q[31:0];
                            rst_p_next = sv_q[95:32];
                        end
                        else
                        begin
                            rst_h_next = '0;
                            rst_p_next = '0;
                        end
                        idx_next   = 2'd0;
                        state_next = S_RSA;
                    end
                    FN_OPEN:
                    begin
                        rsp_next.first_word = 16'(HANDLE_COUNT) - {8'd0, fhc_reg};
                    end
                    FN_PAGES:
                    begin
                        rsp_next.first_word = {5'd0, pg_val};
                    end
                    FN_GETMAP:
                    begin
                        rsp_next.first_word  = win_p_reg[0];
                        rsp_next.second_word = {8'd0, win_h_reg[0]};
                        rsp_next.last        = 1'b0;
                        idx_next             = 2'd1;
                    end
                    FN_MAPSIZE:
                    begin
                        rsp_next.first_word = MAP_SIZE;
                    end
                    default:
                    begin
                        rsp_next.status = ST_UNKNOWN;
                    end
                endcase
            end
            S_RSA:
            begin
                state_next = S_RSB;
            end
            S_RSB:
            begin
                // failed windows are skipped silently
                if (rst_h_reg[idx_reg] == 8'd0 || {5'd0, pg_val} > rst_p_reg[idx_reg])
                begin
                    win_h_next[idx_reg] = rst_h_reg[idx_reg];
                    win_p_next[idx_reg] = rst_p_reg[idx_reg];
                end
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    rsp_next   = '{status: ST_OK, first_word: 16'd0, second_word: 16'd0,
                                   last: 1'b1};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RSA;
                end
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    if (req_reg.func == FN_GETMAP && idx_reg != 2'd0)
                    begin
                        rsp_next.first_word  = win_p_reg[idx_reg];
                        rsp_next.second_word = {8'd0, win_h_reg[idx_reg]};
                        rsp_next.last        = (idx_reg == 2'd3);
                        idx_next             = idx_reg + 2'd1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= 2'd0;
            frame_reg      <= FRAME_RESET;
            free_pages_reg <= 11'(TOTAL_PAGES);
            fhc_reg        <= 8'(HANDLE_COUNT);
            win_h_reg      <= '0;
            win_p_reg      <= '0;
            saved_vld_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_pages_reg <= free_pages_next;
            fhc_reg        <= fhc_next;
            win_h_reg      <= win_h_next;
            win_p_reg      <= win_p_next;
            saved_vld_reg  <= saved_vld_next;
            if (cfg_wr_en)
            begin
                frame_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        rst_h_reg <= rst_h_next;
        rst_p_reg <= rst_p_next;
    end

endmodule

// ===== hw/rtl/empm_checker.sv =====
// port-level checks for the page mapper, bound to the top level
module empm_checker
    import empm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken before first finished");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while result pending");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.first_word == 16'd0
                                          && rsp.second_word == 16'd0 && rsp.last)
        else $error("error result carries data");

endmodule

bind expanded_memory_page_mapper empm_checker u_empm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
